// ===== hw/rtl/acrk_pkg.sv =====
// Package: types, constants and helper functions of the anammox rate kernel.
`timescale 1ns / 1ps
package acrk_pkg;

  localparam int unsigned FRAC_BITS = 40;
  localparam int unsigned DIV_LAT   = FRAC_BITS + 1;
  localparam int unsigned MUL_LAT   = 2;
  localparam int unsigned PIPE_LEN  = DIV_LAT + 5 * MUL_LAT;
  localparam int unsigned NUM_REGS  = 8;

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] COEF_A  = (ONE_Q * 64'd50 + 64'd28) / 64'd57;
  localparam logic [63:0] COEF_B  = (ONE_Q * 64'd100 + 64'd85) / 64'd171;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CFG_RATE_I_MAX  = 3'd0,
    CFG_RATE_S_MAX  = 3'd1,
    CFG_K_OXYGEN    = 3'd2,
    CFG_K_NITRITE   = 3'd3,
    CFG_K_NO        = 3'd4,
    CFG_K_AMMONIUM  = 3'd5,
    CFG_INV_YIELD   = 3'd6,
    CFG_NH_COEF     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [62:0] conc_oxygen;
    logic [62:0] conc_nitrite;
    logic [62:0] conc_nitric_oxide;
    logic [62:0] conc_ammonium;
    logic [62:0] biomass_density;
    logic        cell_active;
    logic        last_cell_in;
  } req_t;

  typedef struct packed {
    logic signed [63:0] delta_nitrate;
    logic signed [63:0] delta_nitrite;
    logic signed [63:0] delta_nitric_oxide;
    logic signed [63:0] delta_ammonium;
    logic [62:0]        gross_growth;
    logic               last_cell_out;
  } rsp_t;

  typedef struct packed {
    logic [62:0] x;
    logic        active;
    logic        last;
  } side_t;

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] pos_out(input logic [63:0] mag);
    return (mag > POS_MAX) ? POS_MAX : mag;
  endfunction

  function automatic logic [63:0] neg_out(input logic [63:0] mag);
    logic [63:0] m;
    m = (mag > NEG_MAG) ? NEG_MAG : mag;
    return 64'd0 - m;
  endfunction

endpackage

// ===== hw/rtl/acrk_div.sv =====
// Pipelined restoring divider: a/(a+b) as a fraction, one quotient bit per stage.
`timescale 1ns / 1ps
module acrk_div import acrk_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [62:0] num_i,
  input  logic [62:0] oth_i,
  output logic [63:0] quo_o
);

  logic [63:0]      d_q  [FRAC_BITS+1];
  logic [63:0]      r_q  [FRAC_BITS+1];
  logic [FRAC_BITS:0] q_q [FRAC_BITS+1];
  logic             dz_q [FRAC_BITS+1];

  logic [63:0]      r_d  [FRAC_BITS+1];
  logic [FRAC_BITS:0] q_d [FRAC_BITS+1];
  logic [63:0]      d0;

  always_comb begin
    logic [63:0] sh;
    logic        take;
    d0 = {1'b0, num_i} + {1'b0, oth_i};
    if ({1'b0, num_i} >= d0) begin
      r_d[0] = {1'b0, num_i} - d0;
      q_d[0] = (FRAC_BITS+1)'(1);
    end else begin
      r_d[0] = {1'b0, num_i};
      q_d[0] = '0;
    end
    for (int k = 1; k <= FRAC_BITS; k++) begin
      sh   = {r_q[k-1][62:0], 1'b0};
      take = r_q[k-1][63] | (sh >= d_q[k-1]);
      r_d[k] = take ? sh - d_q[k-1] : sh;
      q_d[k] = {q_q[k-1][FRAC_BITS-1:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]  <= d0;
      r_q[0]  <= r_d[0];
      q_q[0]  <= q_d[0];
      dz_q[0] <= (d0 == 64'd0);
      for (int k = 1; k <= FRAC_BITS; k++) begin
        d_q[k]  <= d_q[k-1];
        r_q[k]  <= r_d[k];
        q_q[k]  <= q_d[k];
        dz_q[k] <= dz_q[k-1];
      end
    end
  end

  assign quo_o = dz_q[FRAC_BITS] ? ONE_Q : {{(63-FRAC_BITS){1'b0}}, q_q[FRAC_BITS]};

endmodule

// ===== hw/rtl/acrk_qmul.sv =====
// Two-stage fixed-point multiplier with saturation: partial products, then sum.
`timescale 1ns / 1ps
module acrk_qmul import acrk_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] y_o
);

  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] full;
  logic [63:0]  y_d, y_q;

  always_comb begin
    full = {64'd0, ll_q} + ({64'd0, lh_q} << 32) + ({64'd0, hl_q} << 32)
         + {hh_q, 64'd0};
    y_d  = (|full[127:64+FRAC_BITS]) ? '1 : full[64+FRAC_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0]  * b_i[31:0];
      lh_q <= a_i[31:0]  * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
      hh_q <= a_i[63:32] * b_i[63:32];
      y_q  <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== hw/rtl/anammox_cell_rate_kernel_core.sv =====
// Top level: config registers, divider and multiplier pipeline, output register.
// Throughput: one cell per cycle; the 41-stage divider and five multiply layers
// all advance together and hold while the output register is stalled.
// Reset: valid bits clear, config registers return to their reset values.
`timescale 1ns / 1ps
module anammox_cell_rate_kernel_core import acrk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] cfg_q [NUM_REGS];
  logic        en;
  logic        vld_q  [PIPE_LEN];
  side_t       side_q [PIPE_LEN];
  logic        out_valid_q;
  rsp_t        out_q, out_d;

  logic [63:0] f_o, f_no2, f_no, f_nh;
  logic [63:0] fno2_q [2], fno_q [2], fnh_q [4];
  logic [63:0] gross_q [4];
  logic [63:0] gross_sat;
  logic [63:0] p1i, p1s, p2i, p2s, r_i, r_s;
  logic [63:0] m_a, m_b, m_c, m_d, m_e, m_f;
  logic [63:0] o_no3, o_no2, o_no, o_nh;
  logic [63:0] nh_mag;
  logic        nh_neg;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_RATE_I_MAX] <= 64'd0;
      cfg_q[CFG_RATE_S_MAX] <= 64'd0;
      cfg_q[CFG_K_OXYGEN]   <= ONE_Q;
      cfg_q[CFG_K_NITRITE]  <= ONE_Q;
      cfg_q[CFG_K_NO]       <= ONE_Q;
      cfg_q[CFG_K_AMMONIUM] <= ONE_Q;
      cfg_q[CFG_INV_YIELD]  <= ONE_Q;
      cfg_q[CFG_NH_COEF]    <= 64'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_e'(cfg_idx_i) == CFG_NH_COEF) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end else begin
        cfg_q[cfg_idx_i] <= {1'b0, cfg_data_i[62:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_LEN; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_LEN; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{x: in_req_i.biomass_density, active: in_req_i.cell_active,
                     last: in_req_i.last_cell_in};
      for (int k = 1; k < PIPE_LEN; k++) side_q[k] <= side_q[k-1];
      fno2_q[0] <= f_no2;
      fno2_q[1] <= fno2_q[0];
      fno_q[0]  <= f_no;
      fno_q[1]  <= fno_q[0];
      fnh_q[0]  <= f_nh;
      for (int k = 1; k < 4; k++) fnh_q[k] <= fnh_q[k-1];
      gross_q[0] <= add_sat(r_i, r_s);
      for (int k = 1; k < 4; k++) gross_q[k] <= gross_q[k-1];
      out_q <= out_d;
    end
  end

  acrk_div u_div_o (.clk_i, .en_i(en), .num_i(cfg_q[CFG_K_OXYGEN][62:0]),
    .oth_i(in_req_i.conc_oxygen), .quo_o(f_o));
  acrk_div u_div_no2 (.clk_i, .en_i(en), .num_i(in_req_i.conc_nitrite),
    .oth_i(cfg_q[CFG_K_NITRITE][62:0]), .quo_o(f_no2));
  acrk_div u_div_no (.clk_i, .en_i(en), .num_i(in_req_i.conc_nitric_oxide),
    .oth_i(cfg_q[CFG_K_NO][62:0]), .quo_o(f_no));
  acrk_div u_div_nh (.clk_i, .en_i(en), .num_i(in_req_i.conc_ammonium),
    .oth_i(cfg_q[CFG_K_AMMONIUM][62:0]), .quo_o(f_nh));

  acrk_qmul u_l1i (.clk_i, .en_i(en), .a_i(cfg_q[CFG_RATE_I_MAX]), .b_i(f_o), .y_o(p1i));
  acrk_qmul u_l1s (.clk_i, .en_i(en), .a_i(cfg_q[CFG_RATE_S_MAX]), .b_i(f_o), .y_o(p1s));
  acrk_qmul u_l2i (.clk_i, .en_i(en), .a_i(p1i), .b_i(fno2_q[1]), .y_o(p2i));
  acrk_qmul u_l2s (.clk_i, .en_i(en), .a_i(p1s), .b_i(fno_q[1]), .y_o(p2s));
  acrk_qmul u_l3i (.clk_i, .en_i(en), .a_i(p2i), .b_i(fnh_q[3]), .y_o(r_i));
  acrk_qmul u_l3s (.clk_i, .en_i(en), .a_i(p2s), .b_i(fnh_q[3]), .y_o(r_s));

  assign nh_neg = cfg_q[CFG_NH_COEF][63];
  assign nh_mag = nh_neg ? (~cfg_q[CFG_NH_COEF] + 64'd1) : cfg_q[CFG_NH_COEF];

  acrk_qmul u_l4a (.clk_i, .en_i(en), .a_i(r_i), .b_i(COEF_A), .y_o(m_a));
  acrk_qmul u_l4b (.clk_i, .en_i(en), .a_i(r_s), .b_i(COEF_B), .y_o(m_b));
  acrk_qmul u_l4c (.clk_i, .en_i(en), .a_i(add_sat(cfg_q[CFG_INV_YIELD], COEF_A)),
    .b_i(r_i), .y_o(m_c));
  acrk_qmul u_l4d (.clk_i, .en_i(en), .a_i(add_sat(cfg_q[CFG_INV_YIELD], COEF_B)),
    .b_i(r_s), .y_o(m_d));
  acrk_qmul u_l4e (.clk_i, .en_i(en), .a_i(nh_mag), .b_i(r_i), .y_o(m_e));
  acrk_qmul u_l4f (.clk_i, .en_i(en), .a_i(nh_mag), .b_i(r_s), .y_o(m_f));

  acrk_qmul u_l5a (.clk_i, .en_i(en), .a_i(add_sat(m_a, m_b)),
    .b_i({1'b0, side_q[DIV_LAT+7].x}), .y_o(o_no3));
  acrk_qmul u_l5c (.clk_i, .en_i(en), .a_i(m_c),
    .b_i({1'b0, side_q[DIV_LAT+7].x}), .y_o(o_no2));
  acrk_qmul u_l5d (.clk_i, .en_i(en), .a_i(m_d),
    .b_i({1'b0, side_q[DIV_LAT+7].x}), .y_o(o_no));
  acrk_qmul u_l5e (.clk_i, .en_i(en), .a_i(add_sat(m_e, m_f)),
    .b_i({1'b0, side_q[DIV_LAT+7].x}), .y_o(o_nh));

  assign gross_sat = pos_out(gross_q[3]);

  always_comb begin
    out_d = '0;
    if (side_q[PIPE_LEN-1].active) begin
      out_d.delta_nitrate      = pos_out(o_no3);
      out_d.delta_nitrite      = neg_out(o_no2);
      out_d.delta_nitric_oxide = neg_out(o_no);
      out_d.delta_ammonium     = nh_neg ? pos_out(o_nh) : neg_out(o_nh);
    end
    out_d.gross_growth  = gross_sat[62:0];
    out_d.last_cell_out = side_q[PIPE_LEN-1].last;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output register state");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_LEN-1] && !en) |=> vld_q[PIPE_LEN-1])
    else $error("pipeline item lost during stall");

  a_inactive_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[PIPE_LEN-1] && !side_q[PIPE_LEN-1].active)
      |=> (out_rsp_o.delta_nitrate == 64'sd0 && out_rsp_o.delta_ammonium == 64'sd0))
    else $error("inactive cell produced nonzero delta");

endmodule
